// ===== src/softened_gravity_pair_interaction_core_defines.svh =====
// assertion macros for the softened gravity pair interaction core
// no dependencies; included by files that carry concurrent checks
`ifndef SOFTENED_GRAVITY_PAIR_INTERACTION_CORE_DEFINES_SVH
`define SOFTENED_GRAVITY_PAIR_INTERACTION_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SGPI_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SGPI_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sgpi_pkg.sv =====
// shared types and constants for the softened gravity pair interaction core
// no dependencies; used by the channel interfaces and the core
package sgpi_pkg;

  localparam int DATA_W         = 32;
  localparam int IDX_W          = 10;
  localparam int CFG_IDX_W      = 2;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MAX_BODIES_DEF = 1024;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_CONST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOFTENING_SQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 2'd2;

  localparam logic [DATA_W-1:0] GRAV_CONST_RST   = 32'd65536;
  localparam logic [DATA_W-1:0] SOFTENING_SQ_RST = 32'd655;
  localparam logic [DATA_W-1:0] TIME_STEP_RST    = 32'd65536;

  typedef struct packed {
    logic [IDX_W-1:0]         body_index;
    logic signed [DATA_W-1:0] self_x;
    logic signed [DATA_W-1:0] self_y;
    logic signed [DATA_W-1:0] self_z;
    logic [DATA_W-1:0]        self_mass;
    logic signed [DATA_W-1:0] other_x;
    logic signed [DATA_W-1:0] other_y;
    logic signed [DATA_W-1:0] other_z;
    logic [DATA_W-1:0]        other_mass;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_index;
    logic signed [DATA_W-1:0] new_x;
    logic signed [DATA_W-1:0] new_y;
    logic signed [DATA_W-1:0] new_z;
    logic [DATA_W-1:0]        out_mass;
  } out_word_t;

endpackage

// ===== src/sgpi_if.sv =====
// valid/ready channel interfaces for the input and result words
// depends on sgpi_pkg for the payload types
interface sgpi_in_if;
  import sgpi_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sgpi_out_if;
  import sgpi_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/softened_gravity_pair_interaction_core.sv =====
// Softened gravity pair interaction core. One input word describes a body and a
// partner; the core adds G*m*d*dt/(|d|^2+eps^2)^(3/2) into the body's stored
// velocity and returns position plus velocity (Q16.16 at the default
// FRAC_BITS). Words are processed one at a time. The pace is set by the shared
// shift-subtract unit, which produces one square-root bit and then one quotient
// bit per cycle, and by the single shared 32x32 multiplier; the divide is
// skipped when the acceleration saturates. After reset a clearing pass zeroes
// the velocity memory; no word is accepted meanwhile, config writes are. A
// finished result waits in the output register while the next word is taken.
// depends on sgpi_pkg, sgpi_if and the assertion macro header
`include "softened_gravity_pair_interaction_core_defines.svh"

module softened_gravity_pair_interaction_core #(
  parameter int MAX_BODIES = sgpi_pkg::MAX_BODIES_DEF,
  parameter int FRAC_BITS  = sgpi_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sgpi_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [sgpi_pkg::DATA_W-1:0]    cfg_wdata,
  sgpi_in_if.sink                        in_ch,
  sgpi_out_if.source                     out_ch
);
  import sgpi_pkg::*;

  localparam int F      = FRAC_BITS;
  localparam int SQ_NW  = DATA_W + F;
  localparam int SQ_RW  = (SQ_NW + 1) / 2;
  localparam int SH_W   = 2 * SQ_RW;
  localparam int DEN_W  = DATA_W + SQ_RW - F;
  localparam int REM_W  = DEN_W + 1;
  localparam int DIV_N  = DATA_W;
  localparam int CNT_W  = $clog2(((SQ_RW > DIV_N) ? SQ_RW : DIV_N) + 1);
  localparam int SLOT_W = $clog2(MAX_BODIES);
  localparam int MD_W   = $clog2(MAX_BODIES + 1) + IDX_W - 1;
  localparam int MODC_W = $clog2(IDX_W + 1);
  localparam logic [MD_W-1:0]   MD_INIT   = MD_W'(MAX_BODIES) << (IDX_W - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_BODIES - 1);
  localparam logic [63:0]       MAX_U32   = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0]       MAX_S32   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0]       MIN_MAG   = 64'h0000_0000_8000_0000;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_SQ_MUL, S_SQ_ACC, S_SOFT, S_SQRT, S_DEN_MUL, S_DEN,
    S_GM_MUL, S_DIV_CHK, S_DIV, S_RD, S_AX_MUL1, S_AX_T, S_AX_MUL2, S_AX_DV,
    S_AX_ACC, S_AX_POS, S_WR
  } state_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W:0] v);
    if (v[DATA_W] != v[DATA_W-1])
      return v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    return v[DATA_W-1:0];
  endfunction

  // config registers
  logic [DATA_W-1:0] grav_r, soft_r, tstep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r  <= GRAV_CONST_RST;
      soft_r  <= SOFTENING_SQ_RST;
      tstep_r <= TIME_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GRAV_CONST:   grav_r  <= cfg_wdata;
        REG_SOFTENING_SQ: soft_r  <= cfg_wdata;
        REG_TIME_STEP:    tstep_r <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  state_t                   state_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [1:0]               ax_r;
  logic [SLOT_W-1:0]        clr_cnt_r;
  logic [IDX_W-1:0]         idx_r;
  logic [DATA_W-1:0]        mass_r, omass_r;
  logic signed [DATA_W-1:0] self_r [3];
  logic [DATA_W-1:0]        dmag_r [3];
  logic                     dneg_r [3];
  logic [63:0]              acc_r;
  logic [DATA_W-1:0]        s_r;
  logic [SH_W-1:0]          sh_r;
  logic [REM_W-1:0]         rem_r;
  logic [DATA_W-1:0]        qr_r;
  logic [DEN_W-1:0]         den_r;
  logic [DATA_W-1:0]        w_r;
  logic signed [DATA_W-1:0] vnew_r [3];
  logic signed [DATA_W-1:0] np_r [3];
  logic [63:0]              prod_r;
  logic                     out_valid_r;
  out_word_t                out_r;
  logic [IDX_W-1:0]         slot_r;
  logic [MD_W-1:0]          md_r;
  logic [MODC_W-1:0]        modc_r;
  logic [3*DATA_W-1:0]      rd_r;

  logic                     in_acc;
  logic [DATA_W-1:0]        mul_a, mul_b;
  logic [63:0]              soft_sum, m64, q64;
  logic [DATA_W-1:0]        s_val;
  logic [REM_W-1:0]         sq_rem_sh, sq_trial, dv_rem_sh, den_ext;
  logic signed [DATA_W-1:0] vold;
  logic signed [DATA_W-1:0] dv;
  logic                     mem_we;
  logic [SLOT_W-1:0]        mem_waddr, mem_raddr;
  logic [3*DATA_W-1:0]      mem_wdata;
  logic                     out_free;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
  assign out_free     = !out_valid_r || out_ch.ready;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ_MUL: begin
        mul_a = dmag_r[ax_r];
        mul_b = dmag_r[ax_r];
      end
      S_DEN_MUL: begin
        mul_a = s_r;
        mul_b = qr_r;
      end
      S_GM_MUL: begin
        mul_a = grav_r;
        mul_b = omass_r;
      end
      S_AX_MUL1: begin
        mul_a = qr_r;
        mul_b = dmag_r[ax_r];
      end
      S_AX_MUL2: begin
        mul_a = w_r;
        mul_b = tstep_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_comb begin
    soft_sum  = (acc_r >> F) + {32'd0, soft_r};
    s_val     = (soft_sum > MAX_U32) ? MAX_U32[DATA_W-1:0] : soft_sum[DATA_W-1:0];
    sq_rem_sh = {rem_r[REM_W-3:0], sh_r[SH_W-1 -: 2]};
    sq_trial  = REM_W'({qr_r[SQ_RW-1:0], 2'b01});
    dv_rem_sh = {rem_r[REM_W-2:0], sh_r[SH_W-1]};
    den_ext   = {1'b0, den_r};
    q64       = prod_r >> F;
    m64       = prod_r >> F;
    vold      = rd_r[ax_r*DATA_W +: DATA_W];
    if (dneg_r[ax_r])
      dv = (m64 > MIN_MAG) ? {1'b1, {(DATA_W-1){1'b0}}} : -m64[DATA_W-1:0];
    else
      dv = (m64 > MAX_S32) ? MAX_S32[DATA_W-1:0] : m64[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
      modc_r      <= '0;
    end else begin
      if (state_r == S_WR && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      // body index reduced modulo the store depth, one bit per cycle
      if (in_acc) begin
        slot_r <= in_ch.data.body_index;
        md_r   <= MD_INIT;
        modc_r <= MODC_W'(IDX_W);
      end else if (modc_r != '0) begin
        if (MD_W'(slot_r) >= md_r) slot_r <= slot_r - md_r[IDX_W-1:0];
        md_r   <= md_r >> 1;
        modc_r <= modc_r - 1'b1;
      end

      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == SLOT_LAST) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            idx_r   <= in_ch.data.body_index;
            mass_r  <= in_ch.data.self_mass;
            omass_r <= in_ch.data.other_mass;
            self_r[0] <= in_ch.data.self_x;
            self_r[1] <= in_ch.data.self_y;
            self_r[2] <= in_ch.data.self_z;
            for (int k = 0; k < 3; k++) begin
              logic signed [DATA_W:0] o, s, d33;
              logic signed [DATA_W-1:0] d;
              o = (k == 0) ? {in_ch.data.other_x[DATA_W-1], in_ch.data.other_x} :
                  (k == 1) ? {in_ch.data.other_y[DATA_W-1], in_ch.data.other_y} :
                             {in_ch.data.other_z[DATA_W-1], in_ch.data.other_z};
              s = (k == 0) ? {in_ch.data.self_x[DATA_W-1], in_ch.data.self_x} :
                  (k == 1) ? {in_ch.data.self_y[DATA_W-1], in_ch.data.self_y} :
                             {in_ch.data.self_z[DATA_W-1], in_ch.data.self_z};
              d33 = o - s;
              d   = sat32(d33);
              dneg_r[k] <= d[DATA_W-1];
              dmag_r[k] <= d[DATA_W-1] ? (~d + 1'b1) : d;
            end
            acc_r   <= '0;
            ax_r    <= '0;
            state_r <= S_SQ_MUL;
          end
        end
        S_SQ_MUL: state_r <= S_SQ_ACC;
        S_SQ_ACC: begin
          acc_r <= acc_r + prod_r;
          if (ax_r == 2'd2) begin
            state_r <= S_SOFT;
          end else begin
            ax_r    <= ax_r + 1'b1;
            state_r <= S_SQ_MUL;
          end
        end
        S_SOFT: begin
          s_r     <= s_val;
          sh_r    <= SH_W'({s_val, {F{1'b0}}});
          rem_r   <= '0;
          qr_r    <= '0;
          cnt_r   <= CNT_W'(SQ_RW);
          state_r <= S_SQRT;
        end
        // one root bit per cycle
        S_SQRT: begin
          if (sq_rem_sh >= sq_trial) begin
            rem_r <= sq_rem_sh - sq_trial;
            qr_r  <= {qr_r[DATA_W-2:0], 1'b1};
          end else begin
            rem_r <= sq_rem_sh;
            qr_r  <= {qr_r[DATA_W-2:0], 1'b0};
          end
          sh_r  <= {sh_r[SH_W-3:0], 2'b00};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) state_r <= S_DEN_MUL;
        end
        S_DEN_MUL: state_r <= S_DEN;
        S_DEN: begin
          den_r   <= q64[DEN_W-1:0];
          state_r <= S_GM_MUL;
        end
        S_GM_MUL: state_r <= S_DIV_CHK;
        // quotient of 2^32 or more, or a zero divisor, saturates
        S_DIV_CHK: begin
          if ({{(REM_W-DATA_W){1'b0}}, prod_r[63:32]} >= den_ext) begin
            qr_r    <= '1;
            state_r <= S_RD;
          end else begin
            rem_r   <= REM_W'(prod_r[63:32]);
            sh_r    <= {prod_r[DATA_W-1:0], {(SH_W-DATA_W){1'b0}}};
            qr_r    <= '0;
            cnt_r   <= CNT_W'(DIV_N);
            state_r <= S_DIV;
          end
        end
        // one quotient bit per cycle
        S_DIV: begin
          if (dv_rem_sh >= den_ext) begin
            rem_r <= dv_rem_sh - den_ext;
            qr_r  <= {qr_r[DATA_W-2:0], 1'b1};
          end else begin
            rem_r <= dv_rem_sh;
            qr_r  <= {qr_r[DATA_W-2:0], 1'b0};
          end
          sh_r  <= {sh_r[SH_W-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) state_r <= S_RD;
        end
        S_RD: begin
          ax_r    <= '0;
          state_r <= S_AX_MUL1;
        end
        S_AX_MUL1: state_r <= S_AX_T;
        S_AX_T: begin
          w_r     <= (q64 > MAX_U32) ? MAX_U32[DATA_W-1:0] : q64[DATA_W-1:0];
          state_r <= S_AX_MUL2;
        end
        S_AX_MUL2: state_r <= S_AX_DV;
        S_AX_DV: begin
          w_r     <= dv;
          state_r <= S_AX_ACC;
        end
        S_AX_ACC: begin
          vnew_r[ax_r] <= sat32({vold[DATA_W-1], vold} + {w_r[DATA_W-1], w_r});
          state_r      <= S_AX_POS;
        end
        S_AX_POS: begin
          np_r[ax_r] <= sat32({self_r[ax_r][DATA_W-1], self_r[ax_r]} +
                              {vnew_r[ax_r][DATA_W-1], vnew_r[ax_r]});
          if (ax_r == 2'd2) begin
            state_r <= S_WR;
          end else begin
            ax_r    <= ax_r + 1'b1;
            state_r <= S_AX_MUL1;
          end
        end
        S_WR: begin
          if (out_free) begin
            out_r.out_index <= idx_r;
            out_r.new_x     <= np_r[0];
            out_r.new_y     <= np_r[1];
            out_r.new_z     <= np_r[2];
            out_r.out_mass  <= mass_r;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // velocity memory, one row of x, y, z per body
  assign mem_we    = (state_r == S_CLR) || (state_r == S_WR);
  assign mem_raddr = SLOT_W'(slot_r);
  assign mem_waddr = (state_r == S_CLR) ? clr_cnt_r : mem_raddr;
  assign mem_wdata = (state_r == S_CLR) ? '0 : {vnew_r[2], vnew_r[1], vnew_r[0]};

  logic [3*DATA_W-1:0] vel_mem [MAX_BODIES];

  always_ff @(posedge clk) begin
    if (mem_we) vel_mem[mem_waddr] <= mem_wdata;
    rd_r <= vel_mem[mem_raddr];
  end

  `SGPI_ASSERT_NEXT(a_one_word_at_a_time, clk, rst_n, in_acc, !in_ch.ready, "ready after accept")
  `SGPI_ASSERT_NOW(a_div_rem_below_den, clk, rst_n, state_r == S_DIV, rem_r < den_ext, "div remainder")
  `SGPI_ASSERT_NOW(a_slot_ready, clk, rst_n, state_r == S_RD, modc_r == '0, "slot not reduced")
  `SGPI_ASSERT_NOW(a_iter_count, clk, rst_n, state_r == S_SQRT || state_r == S_DIV, cnt_r != '0, "iteration count")

endmodule

// ===== bench/tb_top.sv =====
// testbench for the softened gravity pair interaction core: random and directed words,
// a bit-exact predictor with its own velocity store, and a scoreboard on the result channel
// depends on sgpi_pkg, sgpi_if and the core
module tb_top;
  import sgpi_pkg::*;

  localparam longint unsigned U32_MAX = 64'hFFFF_FFFF;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 150;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_wdata;

  sgpi_in_if  in_ch();
  sgpi_out_if out_ch();

  softened_gravity_pair_interaction_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  in_word_t  pending_words[$];
  out_word_t expected_bodies[$];
  int        error_count = 0;
  int        stall_cycles = 0;
  bit        no_gaps = 0;
  bit        in_fire = 0;

  // predictor copy of registers and velocity store
  logic [31:0] grav_k, soft_k, step_k;
  int          vel_x[MAX_BODIES_DEF];
  int          vel_y[MAX_BODIES_DEF];
  int          vel_z[MAX_BODIES_DEF];

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // applies one pair interaction to the velocity store, returns the moved body
  function out_word_t advance_body(in_word_t w);
    longint          sp[3], op[3], d[3], np[3], dv, v;
    longint unsigned mag[3], sq, s, q, den, a, t, m;
    int              slot;
    out_word_t       r;
    slot = w.body_index % MAX_BODIES_DEF;
    sp[0] = $signed(w.self_x);  sp[1] = $signed(w.self_y);  sp[2] = $signed(w.self_z);
    op[0] = $signed(w.other_x); op[1] = $signed(w.other_y); op[2] = $signed(w.other_z);
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      d[k] = sat32(op[k] - sp[k]);
      mag[k] = d[k] < 0 ? longint'(-d[k]) : longint'(d[k]);
      sq += mag[k] * mag[k];
    end
    s = (sq >> FRAC_BITS_DEF) + soft_k;
    if (s > U32_MAX) s = U32_MAX;
    q = int_sqrt(s << FRAC_BITS_DEF);
    den = (s * q) >> FRAC_BITS_DEF;
    if (den == 0) begin
      a = U32_MAX;
    end else begin
      a = (longint'(grav_k) * longint'(w.other_mass)) / den;
      if (a > U32_MAX) a = U32_MAX;
    end
    for (int k = 0; k < 3; k++) begin
      t = (a * mag[k]) >> FRAC_BITS_DEF;
      if (t > U32_MAX) t = U32_MAX;
      m = (t * longint'(step_k)) >> FRAC_BITS_DEF;
      dv = sat32(d[k] < 0 ? -longint'(m) : longint'(m));
      case (k)
        0: begin v = sat32(longint'(vel_x[slot]) + dv); vel_x[slot] = int'(v); end
        1: begin v = sat32(longint'(vel_y[slot]) + dv); vel_y[slot] = int'(v); end
        default: begin v = sat32(longint'(vel_z[slot]) + dv); vel_z[slot] = int'(v); end
      endcase
      np[k] = sat32(sp[k] + v);
    end
    r.out_index = w.body_index;
    r.new_x = np[0][31:0];
    r.new_y = np[1][31:0];
    r.new_z = np[2][31:0];
    r.out_mass = w.self_mass;
    return r;
  endfunction

  // mostly clustered bodies on a few indexes so velocities build up, some raw noise
  function automatic in_word_t random_pair();
    in_word_t w;
    int       mode;
    logic [31:0] cx, cy, cz;
    mode = $urandom_range(0, 9);
    w.body_index = $urandom_range(0, 1) ? 10'($urandom_range(0, 7)) : 10'($urandom);
    if (mode < 6) begin
      cx = $urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 20)) - 10) << 16;
      cy = $urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 20)) - 10) << 16;
      cz = $urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 20)) - 10) << 16;
      w.self_x = cx; w.self_y = cy; w.self_z = cz;
      w.other_x = cx + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      w.other_y = cy + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      w.other_z = cz + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      w.other_mass = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 18);
    end else begin
      w.self_x = $urandom; w.self_y = $urandom; w.self_z = $urandom;
      w.other_x = $urandom; w.other_y = $urandom; w.other_z = $urandom;
      w.other_mass = $urandom;
    end
    if (mode == 9) begin
      w.other_x = w.self_x; w.other_y = w.self_y; w.other_z = w.self_z;
    end
    w.self_mass = $urandom;
    return w;
  endfunction

  function automatic in_word_t make_pair(logic [9:0] idx, logic [31:0] sx, logic [31:0] ox,
                                         logic [31:0] sm, logic [31:0] om);
    in_word_t w;
    w.body_index = idx;
    w.self_x = sx;  w.self_y = sx;  w.self_z = -sx;
    w.other_x = ox; w.other_y = ox; w.other_z = -ox;
    w.self_mass = sm;
    w.other_mass = om;
    return w;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || expected_bodies.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_fire)) begin
      if (pending_words.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 16)) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_words.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= rst_n && (no_gaps || $urandom_range(0, 99) >= 16);
  end

  // monitor, predictor update and watchdog
  always @(posedge clk) begin
    out_word_t exp_w, got;
    in_fire <= in_ch.valid && in_ch.ready;
    if (cfg_we) begin
      case (cfg_idx)
        REG_GRAV_CONST:   grav_k <= cfg_wdata;
        REG_SOFTENING_SQ: soft_k <= cfg_wdata;
        REG_TIME_STEP:    step_k <= cfg_wdata;
        default: ;
      endcase
    end
    if (in_ch.valid && in_ch.ready) expected_bodies.push_back(advance_body(in_ch.data));
    if (out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_bodies.size() == 0) begin
        $error("unexpected result word, index %0d", got.out_index);
        error_count++;
      end else begin
        exp_w = expected_bodies.pop_front();
        if (got.out_index != exp_w.out_index) begin
          $error("out_index expected %0d got %0d", exp_w.out_index, got.out_index);
          error_count++;
        end
        if (got.new_x != exp_w.new_x) begin
          $error("new_x expected %h got %h", exp_w.new_x, got.new_x);
          error_count++;
        end
        if (got.new_y != exp_w.new_y) begin
          $error("new_y expected %h got %h", exp_w.new_y, got.new_y);
          error_count++;
        end
        if (got.new_z != exp_w.new_z) begin
          $error("new_z expected %h got %h", exp_w.new_z, got.new_z);
          error_count++;
        end
        if (got.out_mass != exp_w.out_mass) begin
          $error("out_mass expected %h got %h", exp_w.out_mass, got.out_mass);
          error_count++;
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [31:0] phase_cfg[6][3];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    grav_k = GRAV_CONST_RST;
    soft_k = SOFTENING_SQ_RST;
    step_k = TIME_STEP_RST;
    for (int i = 0; i < MAX_BODIES_DEF; i++) begin
      vel_x[i] = 0; vel_y[i] = 0; vel_z[i] = 0;
    end
    phase_cfg[0] = '{GRAV_CONST_RST, SOFTENING_SQ_RST, TIME_STEP_RST};
    phase_cfg[1] = '{32'd65536, 32'd0, 32'd65536};
    phase_cfg[2] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    phase_cfg[3] = '{32'd0, 32'd655, 32'd4096};
    phase_cfg[4] = '{32'd6554, 32'd65536, 32'd0};
    phase_cfg[5] = '{$urandom, $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 18)};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 6; p++) begin
      if (p != 0) wait_idle();
      write_reg(REG_GRAV_CONST, phase_cfg[p][0]);
      write_reg(REG_SOFTENING_SQ, phase_cfg[p][1]);
      write_reg(REG_TIME_STEP, phase_cfg[p][2]);
      no_gaps = (p == 2);
      if (p == 0 || p == 1 || p == 2) begin
        // extremes, saturated distance, self pair, zero divisor when eps is zero
        pending_words.push_back(make_pair(10'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                                          32'h0, 32'hFFFF_FFFF));
        pending_words.push_back(make_pair(10'd1023, 32'h7FFF_FFFF, 32'h8000_0000,
                                          32'hFFFF_FFFF, 32'h0));
        pending_words.push_back(make_pair(10'd1023, 32'h7FFF_FFFF, 32'h8000_0000,
                                          32'hFFFF_FFFF, 32'h0001_0000));
        pending_words.push_back(make_pair(10'd5, 32'h0001_0000, 32'h0001_0000,
                                          32'h0001_0000, 32'h0010_0000));
        pending_words.push_back(make_pair(10'd5, 32'h0, 32'h0002_0000,
                                          32'h0001_0000, 32'h0001_0000));
        pending_words.push_back(make_pair(10'd5, 32'h0, 32'h0000_0001,
                                          32'h0001_0000, 32'h0100_0000));
        pending_words.push_back(make_pair(10'd5, 32'h7FFF_0000, 32'h7FFF_0000,
                                          32'h5555_5555, 32'hAAAA_AAAA));
        pending_words.push_back(make_pair(10'd512, 32'hFFFF_0000, 32'h0001_0000,
                                          32'hAAAA_AAAA, 32'h0005_0000));
      end
      for (int i = 0; i < 185; i++) pending_words.push_back(random_pair());
    end

    wait_idle();
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
